[src/cst_pkg.sv]
// cst_pkg: token kind codes, keyword table and character classes
// for the C source tokenizer. No dependencies.
package cst_pkg;

  // Token kinds
  localparam logic [6:0] K_EOF      = 7'd0;
  localparam logic [6:0] K_INVALID  = 7'd1;
  localparam logic [6:0] K_IDENT    = 7'd2;
  localparam logic [6:0] K_INT      = 7'd3;
  localparam logic [6:0] K_FLOAT    = 7'd4;
  localparam logic [6:0] K_STRING   = 7'd5;
  localparam logic [6:0] K_CHAR     = 7'd6;
  localparam logic [6:0] K_LPAREN   = 7'd7;
  localparam logic [6:0] K_RPAREN   = 7'd8;
  localparam logic [6:0] K_LBRACK   = 7'd9;
  localparam logic [6:0] K_RBRACK   = 7'd10;
  localparam logic [6:0] K_LBRACE   = 7'd11;
  localparam logic [6:0] K_RBRACE   = 7'd12;
  localparam logic [6:0] K_SEMI     = 7'd13;
  localparam logic [6:0] K_COMMA    = 7'd14;
  localparam logic [6:0] K_TILDE    = 7'd15;
  localparam logic [6:0] K_QUEST    = 7'd16;
  localparam logic [6:0] K_COLON    = 7'd17;
  localparam logic [6:0] K_HASH     = 7'd18;
  localparam logic [6:0] K_ELLIPSIS = 7'd19;
  localparam logic [6:0] K_DOT      = 7'd20;
  localparam logic [6:0] K_INC      = 7'd21;
  localparam logic [6:0] K_ADDEQ    = 7'd22;
  localparam logic [6:0] K_ADD      = 7'd23;
  localparam logic [6:0] K_DECR     = 7'd24;
  localparam logic [6:0] K_ARROW    = 7'd25;
  localparam logic [6:0] K_SUBEQ    = 7'd26;
  localparam logic [6:0] K_SUB      = 7'd27;
  // operator families: base, base+1, ... (see scanner)
  localparam logic [6:0] K_MULEQ    = 7'd28;
  localparam logic [6:0] K_DIVEQ    = 7'd30;
  localparam logic [6:0] K_MODEQ    = 7'd32;
  localparam logic [6:0] K_XOREQ    = 7'd34;
  localparam logic [6:0] K_EQEQ     = 7'd36;
  localparam logic [6:0] K_NOTEQ    = 7'd38;
  localparam logic [6:0] K_SHLEQ    = 7'd40;
  localparam logic [6:0] K_SHREQ    = 7'd44;
  localparam logic [6:0] K_LAND     = 7'd48;
  localparam logic [6:0] K_LOR      = 7'd51;
  localparam logic [6:0] K_KW_FIRST = 7'd54;

  localparam int KW_COUNT = 38;

  // Keyword text, right-aligned and zero-padded
  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    "_Bool", "_Nonnull", "_Nullable", "auto", "break", "case", "char",
    "const", "continue", "default", "defer", "do", "double", "else", "enum",
    "extern", "float", "for", "goto", "if", "inline", "int", "long",
    "register", "restrict", "return", "short", "signed", "sizeof", "static",
    "struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
    "while"
  };

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Keyword lookup over the first len buffered bytes (len 1..9)
  function automatic logic [6:0] kw_kind(logic [8:0][7:0] kbuf, logic [3:0] len);
    logic [71:0] key;
    logic [6:0]  kind;
    key  = '0;
    kind = K_IDENT;
    for (int k = 0; k < 9; k++) begin
      if (4'(k) < len) key = {key[63:0], kbuf[k]};
    end
    for (int i = 0; i < KW_COUNT; i++) begin
      if (key == KW_TEXT[i]) kind = K_KW_FIRST + 7'(i);
    end
    return kind;
  endfunction

endpackage

[src/c_source_tokenizer.sv]
// c_source_tokenizer: byte-at-a-time C lexer with a three-entry result buffer.
// Depends on cst_pkg (kind codes, keyword table, character classes).
//
//  channel | signals                                    | direction
//  source  | source_valid, source_stall, source_byte    | in (stall out)
//  token   | token_valid, token_stall, token_kind, ...  | out (stall in)
//
// One source byte per cycle unless stalled; a byte is held as lookahead and is
// scanned once the next is accepted, its tokens (up to three) landing in the result
// buffer at the next edge. The buffer drains one token per cycle unless the sink
// stalls; the source stalls while two tokens or more, or one stalled token, remain.
// Reset (rst, synchronous) puts the scanner between tokens at line 1 column 1.
// A zero byte flushes, emits EOF and returns the scanner to that same state.
module c_source_tokenizer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   source_valid,
  output logic                   source_stall,
  input  logic [7:0]             source_byte,
  output logic                   token_valid,
  input  logic                   token_stall,
  output logic [6:0]             token_kind,
  output logic [LINE_BITS-1:0]   token_line,
  output logic [COLUMN_BITS-1:0] token_column,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic [7:0]             char_value,
  output logic                   last_of_run
);

  typedef enum logic [4:0] {
    M_IDLE, M_LINEC, M_BCOPEN, M_BLOCK, M_BCCLOSE, M_IDENT,
    M_ZERO, M_DEC, M_FRAC, M_EXPCHK, M_EXPSIGN, M_EXPDIG, M_HEX, M_BIN, M_SUFFIX,
    M_STR, M_STRESC, M_CHFIRST, M_CHESC, M_CHCLOSE,
    M_DOT, M_ELL2, M_PLUS, M_MINUS, M_OPEQ, M_ANG1, M_ANG2, M_AMPPIPE
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic [6:0]             held;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off;
    logic [LINE_BITS-1:0]   sline;
    logic [COLUMN_BITS-1:0] scol;
    logic [OFFSET_BITS-1:0] soff;
    logic [OFFSET_BITS-1:0] rlen;
    logic                   fseen;
    logic                   counting;
    logic [7:0]             pcv;
    logic [8:0][7:0]        kw;
  } scan_state_t;

  typedef struct packed {
    logic [6:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic [7:0]             cv;
  } result_t;

  typedef struct packed {
    scan_state_t    s;
    result_t [2:0]  r;
    logic [1:0]     n;
  } work_t;

  function automatic scan_state_t f_init();
    scan_state_t s;
    s          = '0;
    s.mode     = M_IDLE;
    s.line     = LINE_BITS'(1);
    s.col      = COLUMN_BITS'(1);
    return s;
  endfunction

  // Step past one byte: offset, line, column and running length
  function automatic work_t f_adv(work_t w, logic [7:0] c);
    w.s.off = w.s.off + OFFSET_BITS'(1);
    if (c == "\n") begin
      if (!(&w.s.line)) w.s.line = w.s.line + LINE_BITS'(1);
      w.s.col = COLUMN_BITS'(1);
    end else if (!(&w.s.col)) begin
      w.s.col = w.s.col + COLUMN_BITS'(1);
    end
    if (w.s.counting && !(&w.s.rlen)) w.s.rlen = w.s.rlen + OFFSET_BITS'(1);
    return w;
  endfunction

  function automatic work_t f_begin(work_t w);
    w.s.sline    = w.s.line;
    w.s.scol     = w.s.col;
    w.s.soff     = w.s.off;
    w.s.rlen     = '0;
    w.s.fseen    = 1'b0;
    w.s.counting = 1'b1;
    return w;
  endfunction

  function automatic work_t f_emit_full(work_t w, logic [6:0] kind,
      logic [OFFSET_BITS-1:0] off, logic [OFFSET_BITS-1:0] len, logic [7:0] cv);
    w.s.counting = 1'b0;
    if (w.n != 2'd3) begin
      w.r[w.n].kind = kind;
      w.r[w.n].line = w.s.sline;
      w.r[w.n].col  = w.s.scol;
      w.r[w.n].off  = off;
      w.r[w.n].len  = len;
      w.r[w.n].cv   = cv;
      w.n = w.n + 2'd1;
    end
    return w;
  endfunction

  function automatic work_t f_emit(work_t w, logic [6:0] kind);
    return f_emit_full(w, kind, w.s.soff, w.s.rlen, 8'd0);
  endfunction

  function automatic work_t f_emit_char(work_t w);
    return f_emit_full(w, cst_pkg::K_CHAR, '0, OFFSET_BITS'(1), w.s.pcv);
  endfunction

  // First byte of a token, or blank / comment opener
  function automatic work_t f_start(work_t w, logic [7:0] c, logic [7:0] n);
    if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
      w = f_adv(w, c);
    end else if (c == "/" && n == "/") begin
      w = f_adv(w, c);
      w.s.mode = M_LINEC;
    end else if (c == "/" && n == "*") begin
      w = f_adv(w, c);
      w.s.mode = M_BCOPEN;
    end else begin
      w = f_begin(w);
      if (cst_pkg::is_alpha(c) || c == "_") begin
        w.s.kw[0] = c;
        w = f_adv(w, c);
        w.s.mode = M_IDENT;
      end else if (cst_pkg::is_digit(c)) begin
        w = f_adv(w, c);
        w.s.mode = (c == "0") ? M_ZERO : M_DEC;
      end else if (c == "\"") begin
        w.s.counting = 1'b0;
        w = f_adv(w, c);
        w.s.soff = w.s.off;
        w.s.counting = 1'b1;
        w.s.mode = M_STR;
      end else if (c == "'") begin
        w = f_adv(w, c);
        w.s.pcv = 8'd0;
        w.s.mode = M_CHFIRST;
      end else begin
        w = f_adv(w, c);
        if      (c == "(") w = f_emit(w, cst_pkg::K_LPAREN);
        else if (c == ")") w = f_emit(w, cst_pkg::K_RPAREN);
        else if (c == "[") w = f_emit(w, cst_pkg::K_LBRACK);
        else if (c == "]") w = f_emit(w, cst_pkg::K_RBRACK);
        else if (c == "{") w = f_emit(w, cst_pkg::K_LBRACE);
        else if (c == "}") w = f_emit(w, cst_pkg::K_RBRACE);
        else if (c == ";") w = f_emit(w, cst_pkg::K_SEMI);
        else if (c == ",") w = f_emit(w, cst_pkg::K_COMMA);
        else if (c == "~") w = f_emit(w, cst_pkg::K_TILDE);
        else if (c == "?") w = f_emit(w, cst_pkg::K_QUEST);
        else if (c == ":") w = f_emit(w, cst_pkg::K_COLON);
        else if (c == "#") w = f_emit(w, cst_pkg::K_HASH);
        else if (c == ".") w.s.mode = M_DOT;
        else if (c == "+") w.s.mode = M_PLUS;
        else if (c == "-") w.s.mode = M_MINUS;
        else if (c == "*") begin w.s.held = cst_pkg::K_MULEQ; w.s.mode = M_OPEQ; end
        else if (c == "/") begin w.s.held = cst_pkg::K_DIVEQ; w.s.mode = M_OPEQ; end
        else if (c == "%") begin w.s.held = cst_pkg::K_MODEQ; w.s.mode = M_OPEQ; end
        else if (c == "^") begin w.s.held = cst_pkg::K_XOREQ; w.s.mode = M_OPEQ; end
        else if (c == "=") begin w.s.held = cst_pkg::K_EQEQ; w.s.mode = M_OPEQ; end
        else if (c == "!") begin w.s.held = cst_pkg::K_NOTEQ; w.s.mode = M_OPEQ; end
        else if (c == "<") begin w.s.held = cst_pkg::K_SHLEQ; w.s.mode = M_ANG1; end
        else if (c == ">") begin w.s.held = cst_pkg::K_SHREQ; w.s.mode = M_ANG1; end
        else if (c == "&") begin w.s.held = cst_pkg::K_LAND; w.s.mode = M_AMPPIPE; end
        else if (c == "|") begin w.s.held = cst_pkg::K_LOR; w.s.mode = M_AMPPIPE; end
        else w = f_emit(w, cst_pkg::K_INVALID);
      end
    end
    return w;
  endfunction

  // Scan byte c with next byte n; a byte may pass through a few modes
  function automatic work_t f_scan(work_t w, logic [7:0] c, logic [7:0] n);
    logic       go;
    logic [7:0] ch;
    logic [6:0] kk;
    go = 1'b1;
    for (int it = 0; it < 7; it++) begin
      if (go) begin
        go = 1'b0;
        unique case (w.s.mode)
          M_IDLE: if (c != 8'd0) w = f_start(w, c, n);
          M_LINEC: begin
            if (c == 8'd0 || c == "\n") begin w.s.mode = M_IDLE; go = 1'b1; end
            else w = f_adv(w, c);
          end
          M_BCOPEN: begin w = f_adv(w, c); w.s.mode = M_BLOCK; end
          M_BLOCK: begin
            if (c == 8'd0) w.s.mode = M_IDLE;
            else if (c == "*" && n == "/") begin w = f_adv(w, c); w.s.mode = M_BCCLOSE; end
            else w = f_adv(w, c);
          end
          M_BCCLOSE: begin w = f_adv(w, c); w.s.mode = M_IDLE; end
          M_IDENT: begin
            if (cst_pkg::is_alnum(c) || c == "_") begin
              if (w.s.rlen < OFFSET_BITS'(9)) w.s.kw[w.s.rlen[3:0]] = c;
              w = f_adv(w, c);
            end else begin
              if (w.s.rlen >= OFFSET_BITS'(1) && w.s.rlen <= OFFSET_BITS'(9))
                kk = cst_pkg::kw_kind(w.s.kw, w.s.rlen[3:0]);
              else
                kk = cst_pkg::K_IDENT;
              w = f_emit(w, kk);
              w.s.mode = M_IDLE;
              go = 1'b1;
            end
          end
          M_ZERO: begin
            if (c == "x" || c == "X") begin w = f_adv(w, c); w.s.mode = M_HEX; end
            else if (c == "b" || c == "B") begin w = f_adv(w, c); w.s.mode = M_BIN; end
            else begin w.s.mode = M_DEC; go = 1'b1; end
          end
          M_DEC: begin
            if (cst_pkg::is_digit(c)) w = f_adv(w, c);
            else if (c == "." && cst_pkg::is_digit(n)) begin
              w.s.fseen = 1'b1; w = f_adv(w, c); w.s.mode = M_FRAC;
            end else begin w.s.mode = M_EXPCHK; go = 1'b1; end
          end
          M_FRAC: begin
            if (cst_pkg::is_digit(c)) w = f_adv(w, c);
            else begin w.s.mode = M_EXPCHK; go = 1'b1; end
          end
          M_EXPCHK: begin
            if (c == "e" || c == "E") begin
              w.s.fseen = 1'b1; w = f_adv(w, c); w.s.mode = M_EXPSIGN;
            end else begin w.s.mode = M_SUFFIX; go = 1'b1; end
          end
          M_EXPSIGN: begin
            if (c == "+" || c == "-") begin w = f_adv(w, c); w.s.mode = M_EXPDIG; end
            else begin w.s.mode = M_EXPDIG; go = 1'b1; end
          end
          M_EXPDIG: begin
            if (cst_pkg::is_digit(c)) w = f_adv(w, c);
            else begin w.s.mode = M_SUFFIX; go = 1'b1; end
          end
          M_HEX: begin
            if (cst_pkg::is_xdigit(c)) w = f_adv(w, c);
            else begin w.s.mode = M_SUFFIX; go = 1'b1; end
          end
          M_BIN: begin
            if (c == "0" || c == "1") w = f_adv(w, c);
            else begin w.s.mode = M_SUFFIX; go = 1'b1; end
          end
          M_SUFFIX: begin
            if (cst_pkg::is_alnum(c)) w = f_adv(w, c);
            else begin
              w = f_emit(w, w.s.fseen ? cst_pkg::K_FLOAT : cst_pkg::K_INT);
              w.s.mode = M_IDLE;
              go = 1'b1;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              w = f_emit(w, cst_pkg::K_STRING); w = f_adv(w, c); w.s.mode = M_IDLE;
            end else if (c == 8'd0) begin
              w = f_emit(w, cst_pkg::K_STRING); w.s.mode = M_IDLE;
            end else begin
              w = f_adv(w, c);
              if (c == "\\") w.s.mode = M_STRESC;
            end
          end
          M_STRESC: begin
            if (c == 8'd0) begin w = f_emit(w, cst_pkg::K_STRING); w.s.mode = M_IDLE; end
            else begin w = f_adv(w, c); w.s.mode = M_STR; end
          end
          M_CHFIRST: begin
            if (c == 8'd0) begin
              w.s.pcv = 8'd0; w = f_emit_char(w); w.s.mode = M_IDLE;
            end else if (c == "\\") begin
              w = f_adv(w, c); w.s.mode = M_CHESC;
            end else begin
              w.s.pcv = c; w = f_adv(w, c); w.s.mode = M_CHCLOSE;
            end
          end
          M_CHESC: begin
            if (c == 8'd0) begin
              w.s.pcv = 8'd0; w = f_emit_char(w); w.s.mode = M_IDLE;
            end else begin
              if      (c == "n") w.s.pcv = "\n";
              else if (c == "t") w.s.pcv = "\t";
              else if (c == "r") w.s.pcv = "\r";
              else if (c == "0") w.s.pcv = 8'd0;
              else               w.s.pcv = c;
              w = f_adv(w, c);
              w.s.mode = M_CHCLOSE;
            end
          end
          M_CHCLOSE: begin
            if (c == "'") begin w = f_adv(w, c); w = f_emit_char(w); w.s.mode = M_IDLE; end
            else begin w = f_emit_char(w); w.s.mode = M_IDLE; go = 1'b1; end
          end
          M_DOT: begin
            if (c == "." && n == ".") begin w = f_adv(w, c); w.s.mode = M_ELL2; end
            else begin w = f_emit(w, cst_pkg::K_DOT); w.s.mode = M_IDLE; go = 1'b1; end
          end
          M_ELL2: begin
            w = f_adv(w, c); w = f_emit(w, cst_pkg::K_ELLIPSIS); w.s.mode = M_IDLE;
          end
          M_PLUS: begin
            w.s.mode = M_IDLE;
            if (c == "+") begin w = f_adv(w, c); w = f_emit(w, cst_pkg::K_INC); end
            else if (c == "=") begin w = f_adv(w, c); w = f_emit(w, cst_pkg::K_ADDEQ); end
            else begin w = f_emit(w, cst_pkg::K_ADD); go = 1'b1; end
          end
          M_MINUS: begin
            w.s.mode = M_IDLE;
            if (c == "-") begin w = f_adv(w, c); w = f_emit(w, cst_pkg::K_DECR); end
            else if (c == ">") begin w = f_adv(w, c); w = f_emit(w, cst_pkg::K_ARROW); end
            else if (c == "=") begin w = f_adv(w, c); w = f_emit(w, cst_pkg::K_SUBEQ); end
            else begin w = f_emit(w, cst_pkg::K_SUB); go = 1'b1; end
          end
          M_OPEQ: begin
            w.s.mode = M_IDLE;
            if (c == "=") begin w = f_adv(w, c); w = f_emit(w, w.s.held); end
            else begin w = f_emit(w, w.s.held + 7'd1); go = 1'b1; end
          end
          M_ANG1: begin
            ch = (w.s.held == cst_pkg::K_SHLEQ) ? "<" : ">";
            if (c == ch) begin w = f_adv(w, c); w.s.mode = M_ANG2; end
            else if (c == "=") begin
              w = f_adv(w, c); w = f_emit(w, w.s.held + 7'd2); w.s.mode = M_IDLE;
            end else begin
              w = f_emit(w, w.s.held + 7'd3); w.s.mode = M_IDLE; go = 1'b1;
            end
          end
          M_ANG2: begin
            w.s.mode = M_IDLE;
            if (c == "=") begin w = f_adv(w, c); w = f_emit(w, w.s.held); end
            else begin w = f_emit(w, w.s.held + 7'd1); go = 1'b1; end
          end
          M_AMPPIPE: begin
            ch = (w.s.held == cst_pkg::K_LAND) ? "&" : "|";
            w.s.mode = M_IDLE;
            if (c == ch) begin w = f_adv(w, c); w = f_emit(w, w.s.held); end
            else if (c == "=") begin w = f_adv(w, c); w = f_emit(w, w.s.held + 7'd1); end
            else begin w = f_emit(w, w.s.held + 7'd2); go = 1'b1; end
          end
          default: begin w.s.mode = M_IDLE; go = 1'b1; end
        endcase
      end
    end
    return w;
  endfunction

  // State registers
  scan_state_t   st;
  logic [7:0]    la;
  logic          la_valid;
  result_t [2:0] rbuf;
  logic [1:0]    head;
  logic [1:0]    cnt;

  logic  in_fire;
  logic  out_fire;
  work_t w_next;

  assign token_valid  = (cnt != 2'd0);
  assign out_fire     = token_valid && !token_stall;
  assign source_stall = !((cnt == 2'd0) || (cnt == 2'd1 && !token_stall));
  assign in_fire      = source_valid && !source_stall;

  // Scan the held lookahead byte, with the accepted byte as its next byte
  always_comb begin
    w_next   = '0;
    w_next.s = st;
    if (source_byte != 8'd0) begin
      if (la_valid) w_next = f_scan(w_next, la, source_byte);
    end else begin
      if (la_valid) w_next = f_scan(w_next, la, 8'd0);
      w_next = f_scan(w_next, 8'd0, 8'd0);
      w_next = f_begin(w_next);
      w_next = f_emit(w_next, cst_pkg::K_EOF);
    end
  end

  // Scanner state, lookahead and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= f_init();
      la_valid <= 1'b0;
      cnt      <= 2'd0;
      head     <= 2'd0;
    end else begin
      if (out_fire) begin
        head <= head + 2'd1;
        cnt  <= cnt - 2'd1;
      end
      if (in_fire) begin
        rbuf <= w_next.r;
        head <= 2'd0;
        cnt  <= w_next.n;
        if (source_byte != 8'd0) begin
          st       <= w_next.s;
          la       <= source_byte;
          la_valid <= 1'b1;
        end else begin
          st       <= f_init();
          la_valid <= 1'b0;
        end
      end
    end
  end

  // Result fields from the buffer head
  assign token_kind   = rbuf[head].kind;
  assign token_line   = rbuf[head].line;
  assign token_column = rbuf[head].col;
  assign start_offset = rbuf[head].off;
  assign token_length = rbuf[head].len;
  assign char_value   = rbuf[head].cv;
  assign last_of_run  = (cnt == 2'd1);

  // Checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> source_stall)
    else $error("source taken while tokens still queued");

  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && source_byte == 8'd0) |=> (!la_valid && st.mode == M_IDLE && token_valid))
    else $error("end of source did not clear scanner");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind == cst_pkg::K_EOF) |-> last_of_run)
    else $error("EOF token not last of its run");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} + {1'b0, cnt}) <= 3'd3)
    else $error("result buffer index overrun");

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for c_source_tokenizer (byte in, tokens out).
// Depends on cst_pkg for kind codes and the keyword table; carries its own lexer model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam logic [23:0] OFF_MAX  = 24'hFFFFFF;
  localparam logic [19:0] LINE_TOP = 20'hFFFFF;
  localparam logic [15:0] COL_TOP  = 16'hFFFF;

  typedef struct packed {
    logic [6:0]  kind;
    logic [19:0] line;
    logic [15:0] column;
    logic [23:0] offset;
    logic [23:0] length;
    logic [7:0]  cval;
    logic        last;
  } token_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LINE_CMT, S_BLK_OPEN, S_BLK, S_BLK_CLOSE, S_IDENT,
    S_ZERO, S_DEC, S_FRAC, S_EXP, S_EXP_SIGN, S_EXP_DIG, S_HEX, S_BIN, S_SUFFIX,
    S_STR, S_STR_ESC, S_CH_FIRST, S_CH_ESC, S_CH_CLOSE,
    S_DOT, S_ELLIP, S_PLUS, S_MINUS, S_OP_EQ, S_ANG1, S_ANG2, S_AMP_PIPE
  } lex_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        source_valid = 1'b0;
  logic        source_stall;
  logic [7:0]  source_byte = 8'd0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [6:0]  token_kind;
  logic [19:0] token_line;
  logic [15:0] token_column;
  logic [23:0] start_offset;
  logic [23:0] token_length;
  logic [7:0]  char_value;
  logic        last_of_run;

  c_source_tokenizer dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- lexer model state ----------------
  lex_mode_t   mode;
  logic [7:0]  la_byte;
  logic        la_have;
  logic [7:0]  kw_buf [9];
  logic [23:0] cur_off;
  logic [19:0] cur_line;
  logic [15:0] cur_col;
  logic [19:0] st_line;
  logic [15:0] st_col;
  logic [23:0] st_off;
  logic [23:0] run_len;
  logic        saw_float;
  logic [7:0]  chr_val;
  logic [6:0]  op_base;
  logic        counting;
  token_t      step_toks [3];
  int          step_n;

  token_t tokens_due [$];
  logic [7:0] byte_q [$];

  int n_bytes = 0, n_tokens = 0, n_sources = 0, n_errors = 0;

  task automatic lexer_clear();
    mode = S_IDLE; la_byte = 8'd0; la_have = 1'b0;
    cur_off = 24'd0; cur_line = 20'd1; cur_col = 16'd1;
    st_line = 20'd0; st_col = 16'd0; st_off = 24'd0;
    run_len = 24'd0; saw_float = 1'b0; chr_val = 8'd0; op_base = 7'd0; counting = 1'b0;
  endtask

  task automatic step_pos(logic [7:0] c);
    cur_off = cur_off + 24'd1;
    if (c == 8'h0A) begin
      if (cur_line < LINE_TOP) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col < COL_TOP) cur_col++;
    if (counting && run_len < OFF_MAX) run_len++;
  endtask

  task automatic mark_start();
    st_line = cur_line; st_col = cur_col; st_off = cur_off;
    run_len = 24'd0; saw_float = 1'b0; counting = 1'b1;
  endtask

  task automatic put_tok(logic [6:0] k, logic [23:0] o, logic [23:0] l, logic [7:0] v);
    counting = 1'b0;
    if (step_n < 3) begin
      step_toks[step_n] = '{k, st_line, st_col, o, l, v, 1'b0};
      step_n++;
    end
  endtask

  task automatic put_plain(logic [6:0] k);
    put_tok(k, st_off, run_len, 8'd0);
  endtask

  function automatic logic [6:0] word_kind();
    logic [71:0] key;
    logic [6:0]  k;
    key = '0;
    k = cst_pkg::K_IDENT;
    if (run_len >= 1 && run_len <= 9) begin
      for (int i = 0; i < 9; i++)
        if (i < run_len) key = {key[63:0], kw_buf[i]};
      for (int i = 0; i < cst_pkg::KW_COUNT; i++)
        if (key == cst_pkg::KW_TEXT[i]) k = cst_pkg::K_KW_FIRST + 7'(i);
    end
    return k;
  endfunction

  function automatic logic ident_char(logic [7:0] c);
    return cst_pkg::is_alnum(c) || c == "_";
  endfunction

  // first byte of a token, seen from between tokens
  task automatic open_token(logic [7:0] c, logic [7:0] n);
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
      step_pos(c); return;
    end
    if (c == "/" && n == "/") begin step_pos(c); mode = S_LINE_CMT; return; end
    if (c == "/" && n == "*") begin step_pos(c); mode = S_BLK_OPEN; return; end
    mark_start();
    if (cst_pkg::is_alpha(c) || c == "_") begin
      kw_buf[0] = c; step_pos(c); mode = S_IDENT; return;
    end
    if (cst_pkg::is_digit(c)) begin
      step_pos(c); mode = (c == "0") ? S_ZERO : S_DEC; return;
    end
    if (c == 8'h22) begin
      counting = 1'b0; step_pos(c); st_off = cur_off; counting = 1'b1;
      mode = S_STR; return;
    end
    if (c == 8'h27) begin
      step_pos(c); chr_val = 8'd0; mode = S_CH_FIRST; return;
    end
    step_pos(c);
    case (c)
      "(": put_plain(cst_pkg::K_LPAREN);
      ")": put_plain(cst_pkg::K_RPAREN);
      "[": put_plain(cst_pkg::K_LBRACK);
      "]": put_plain(cst_pkg::K_RBRACK);
      "{": put_plain(cst_pkg::K_LBRACE);
      "}": put_plain(cst_pkg::K_RBRACE);
      ";": put_plain(cst_pkg::K_SEMI);
      ",": put_plain(cst_pkg::K_COMMA);
      "~": put_plain(cst_pkg::K_TILDE);
      "?": put_plain(cst_pkg::K_QUEST);
      ":": put_plain(cst_pkg::K_COLON);
      "#": put_plain(cst_pkg::K_HASH);
      ".": mode = S_DOT;
      "+": mode = S_PLUS;
      "-": mode = S_MINUS;
      "*": begin op_base = cst_pkg::K_MULEQ; mode = S_OP_EQ; end
      "/": begin op_base = cst_pkg::K_DIVEQ; mode = S_OP_EQ; end
      "%": begin op_base = cst_pkg::K_MODEQ; mode = S_OP_EQ; end
      "^": begin op_base = cst_pkg::K_XOREQ; mode = S_OP_EQ; end
      "=": begin op_base = cst_pkg::K_EQEQ; mode = S_OP_EQ; end
      "!": begin op_base = cst_pkg::K_NOTEQ; mode = S_OP_EQ; end
      "<": begin op_base = cst_pkg::K_SHLEQ; mode = S_ANG1; end
      ">": begin op_base = cst_pkg::K_SHREQ; mode = S_ANG1; end
      "&": begin op_base = cst_pkg::K_LAND; mode = S_AMP_PIPE; end
      "|": begin op_base = cst_pkg::K_LOR; mode = S_AMP_PIPE; end
      default: put_plain(cst_pkg::K_INVALID);
    endcase
  endtask

  // scan byte c with the following byte n known (0 at end of source)
  task automatic scan(logic [7:0] c, logic [7:0] n);
    logic rescan;
    logic [7:0] pair;
    do begin
      rescan = 1'b0;
      case (mode)
        S_IDLE: if (c != 0) open_token(c, n);
        S_LINE_CMT:
          if (c == 0 || c == 8'h0A) begin mode = S_IDLE; rescan = 1'b1; end
          else step_pos(c);
        S_BLK_OPEN: begin step_pos(c); mode = S_BLK; end
        S_BLK:
          if (c == 0) mode = S_IDLE;
          else if (c == "*" && n == "/") begin step_pos(c); mode = S_BLK_CLOSE; end
          else step_pos(c);
        S_BLK_CLOSE: begin step_pos(c); mode = S_IDLE; end
        S_IDENT:
          if (ident_char(c)) begin
            if (run_len < 9) kw_buf[run_len] = c;
            step_pos(c);
          end else begin put_plain(word_kind()); mode = S_IDLE; rescan = 1'b1; end
        S_ZERO:
          if (c == "x" || c == "X") begin step_pos(c); mode = S_HEX; end
          else if (c == "b" || c == "B") begin step_pos(c); mode = S_BIN; end
          else begin mode = S_DEC; rescan = 1'b1; end
        S_DEC:
          if (cst_pkg::is_digit(c)) step_pos(c);
          else if (c == "." && cst_pkg::is_digit(n)) begin
            saw_float = 1'b1; step_pos(c); mode = S_FRAC;
          end else begin mode = S_EXP; rescan = 1'b1; end
        S_FRAC:
          if (cst_pkg::is_digit(c)) step_pos(c);
          else begin mode = S_EXP; rescan = 1'b1; end
        S_EXP:
          if (c == "e" || c == "E") begin
            saw_float = 1'b1; step_pos(c); mode = S_EXP_SIGN;
          end else begin mode = S_SUFFIX; rescan = 1'b1; end
        S_EXP_SIGN:
          if (c == "+" || c == "-") begin step_pos(c); mode = S_EXP_DIG; end
          else begin mode = S_EXP_DIG; rescan = 1'b1; end
        S_EXP_DIG:
          if (cst_pkg::is_digit(c)) step_pos(c);
          else begin mode = S_SUFFIX; rescan = 1'b1; end
        S_HEX:
          if (cst_pkg::is_xdigit(c)) step_pos(c);
          else begin mode = S_SUFFIX; rescan = 1'b1; end
        S_BIN:
          if (c == "0" || c == "1") step_pos(c);
          else begin mode = S_SUFFIX; rescan = 1'b1; end
        S_SUFFIX:
          if (cst_pkg::is_alnum(c)) step_pos(c);
          else begin
            put_plain(saw_float ? cst_pkg::K_FLOAT : cst_pkg::K_INT);
            mode = S_IDLE; rescan = 1'b1;
          end
        S_STR:
          if (c == 8'h22) begin
            put_plain(cst_pkg::K_STRING); step_pos(c); mode = S_IDLE;
          end else if (c == 0) begin put_plain(cst_pkg::K_STRING); mode = S_IDLE; end
          else begin step_pos(c); if (c == 8'h5C) mode = S_STR_ESC; end
        S_STR_ESC:
          if (c == 0) begin put_plain(cst_pkg::K_STRING); mode = S_IDLE; end
          else begin step_pos(c); mode = S_STR; end
        S_CH_FIRST:
          if (c == 0) begin
            chr_val = 8'd0; put_tok(cst_pkg::K_CHAR, 24'd0, 24'd1, chr_val); mode = S_IDLE;
          end else if (c == 8'h5C) begin step_pos(c); mode = S_CH_ESC; end
          else begin chr_val = c; step_pos(c); mode = S_CH_CLOSE; end
        S_CH_ESC:
          if (c == 0) begin
            chr_val = 8'd0; put_tok(cst_pkg::K_CHAR, 24'd0, 24'd1, chr_val); mode = S_IDLE;
          end else begin
            case (c)
              "n": chr_val = 8'h0A;
              "t": chr_val = 8'h09;
              "r": chr_val = 8'h0D;
              "0": chr_val = 8'h00;
              default: chr_val = c;
            endcase
            step_pos(c); mode = S_CH_CLOSE;
          end
        S_CH_CLOSE:
          if (c == 8'h27) begin
            step_pos(c); put_tok(cst_pkg::K_CHAR, 24'd0, 24'd1, chr_val); mode = S_IDLE;
          end else begin
            put_tok(cst_pkg::K_CHAR, 24'd0, 24'd1, chr_val); mode = S_IDLE; rescan = 1'b1;
          end
        S_DOT:
          if (c == "." && n == ".") begin step_pos(c); mode = S_ELLIP; end
          else begin put_plain(cst_pkg::K_DOT); mode = S_IDLE; rescan = 1'b1; end
        S_ELLIP: begin step_pos(c); put_plain(cst_pkg::K_ELLIPSIS); mode = S_IDLE; end
        S_PLUS: begin
          mode = S_IDLE;
          if (c == "+") begin step_pos(c); put_plain(cst_pkg::K_INC); end
          else if (c == "=") begin step_pos(c); put_plain(cst_pkg::K_ADDEQ); end
          else begin put_plain(cst_pkg::K_ADD); rescan = 1'b1; end
        end
        S_MINUS: begin
          mode = S_IDLE;
          if (c == "-") begin step_pos(c); put_plain(cst_pkg::K_DECR); end
          else if (c == ">") begin step_pos(c); put_plain(cst_pkg::K_ARROW); end
          else if (c == "=") begin step_pos(c); put_plain(cst_pkg::K_SUBEQ); end
          else begin put_plain(cst_pkg::K_SUB); rescan = 1'b1; end
        end
        S_OP_EQ: begin
          mode = S_IDLE;
          if (c == "=") begin step_pos(c); put_plain(op_base); end
          else begin put_plain(op_base + 7'd1); rescan = 1'b1; end
        end
        S_ANG1: begin
          pair = (op_base == cst_pkg::K_SHLEQ) ? "<" : ">";
          if (c == pair) begin step_pos(c); mode = S_ANG2; end
          else if (c == "=") begin step_pos(c); put_plain(op_base + 7'd2); mode = S_IDLE; end
          else begin put_plain(op_base + 7'd3); mode = S_IDLE; rescan = 1'b1; end
        end
        S_ANG2: begin
          mode = S_IDLE;
          if (c == "=") begin step_pos(c); put_plain(op_base); end
          else begin put_plain(op_base + 7'd1); rescan = 1'b1; end
        end
        S_AMP_PIPE: begin
          pair = (op_base == cst_pkg::K_LAND) ? "&" : "|";
          mode = S_IDLE;
          if (c == pair) begin step_pos(c); put_plain(op_base); end
          else if (c == "=") begin step_pos(c); put_plain(op_base + 7'd1); end
          else begin put_plain(op_base + 7'd2); rescan = 1'b1; end
        end
        default: begin mode = S_IDLE; rescan = 1'b1; end
      endcase
    end while (rescan);
  endtask

  // one accepted source byte: queue the tokens it yields
  task automatic lex_byte(logic [7:0] b);
    step_n = 0;
    if (b != 0) begin
      if (la_have) scan(la_byte, b);
      la_byte = b;
      la_have = 1'b1;
    end else begin
      if (la_have) scan(la_byte, 8'd0);
      scan(8'd0, 8'd0);
      mark_start();
      put_plain(cst_pkg::K_EOF);
      lexer_clear();
    end
    if (step_n > 0) step_toks[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) tokens_due.push_back(step_toks[i]);
  endtask

  // ---------------- driver: bursts with random gaps ----------------
  int burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      source_valid <= 1'b0;
    end else begin
      if (source_valid && !source_stall) begin
        lex_byte(source_byte);
        n_bytes++;
      end
      if (!source_valid || !source_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          source_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          source_valid <= 1'b1;
          source_byte <= byte_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          source_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- long receiver hold-off ----------------
  int cyc = 0;
  int hold_left = 0;
  logic long_hold = 1'b0;

  always @(posedge clk) begin
    cyc++;
    if (cyc == 120) hold_left = 300;
    if (hold_left > 0) hold_left--;
    long_hold <= (hold_left > 0);
  end

  // ---------------- monitor and receiver stall pattern ----------------
  int stall_phase = 0;

  always @(posedge clk) begin
    token_t got, want;
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (token_valid && !token_stall) begin
        got = '{token_kind, token_line, token_column, start_offset, token_length,
                char_value, last_of_run};
        n_tokens++;
        if (tokens_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected token kind=%0d line=%0d col=%0d", got.kind,
                     got.line, got.column);
        end else begin
          want = tokens_due.pop_front();
          if (got != want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("ERROR: token mismatch (kind line col off len val last)");
              $display("  expected %0d %0d %0d %0d %0d %0d %0d", want.kind, want.line,
                       want.column, want.offset, want.length, want.cval, want.last);
              $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got.kind, got.line,
                       got.column, got.offset, got.length, got.cval, got.last);
            end
          end
        end
      end
      // stall pattern: quiet stretches, light and heavy stalling
      stall_phase = (stall_phase + 1) % 192;
      if (stall_phase < 64)
        token_stall <= long_hold;
      else if (stall_phase < 128)
        token_stall <= long_hold || ($urandom_range(0, 3) == 0);
      else
        token_stall <= long_hold || ($urandom_range(0, 1) == 0);
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((source_valid && !source_stall) || (token_valid && !token_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic end_source();
    byte_q.push_back(8'd0);
    n_sources++;
  endtask

  string words [] = '{"int", "while", "_Nullable", "_Nonnull", "defer", "volatile",
                      "_Bool", "do", "x_1", "abcdefghij", "Z", "_", "unsignedx"};
  string nums  [] = '{"0x1fUL", "0XaB", "0b101", "0B2", "123", "1.5e+3f", "0", "07.",
                      "3.x", "1e5", "2E-7L", "9.25", "0x"};
  string lits  [] = '{"\"ab\"", "\"a\\\"b\"", "\"\"", "'a'", "'\\n'", "'\\t'", "'\\r'",
                      "'\\0'", "'\\q'", "'z", "''"};
  string puncts[] = '{"(", ")", "[", "]", "{", "}", ";", ",", "~", "?", ":", "#", "...",
                      ".", "..", "++", "+=", "+", "--", "->", "-=", "-", "*=", "*", "/=",
                      "/", "%=", "%", "^=", "^", "==", "=", "!=", "!", "<<=", "<<", "<=",
                      "<", ">>=", ">>", ">=", ">", "&&", "&=", "&", "||", "|=", "|", "@"};
  string cmts  [] = '{"// note\n", "/* a * b */", "/**/", "//\n", "/* x\n y */"};

  task automatic add_piece();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) add_text(words[$urandom_range(0, words.size()-1)]);
    else if (pick < 35) add_text(nums[$urandom_range(0, nums.size()-1)]);
    else if (pick < 47) add_text(lits[$urandom_range(0, lits.size()-1)]);
    else if (pick < 75) add_text(puncts[$urandom_range(0, puncts.size()-1)]);
    else if (pick < 81) add_text(cmts[$urandom_range(0, cmts.size()-1)]);
    else if (pick < 94) begin
      case ($urandom_range(0, 3))
        0: byte_q.push_back(" ");
        1: byte_q.push_back(8'h0A);
        2: byte_q.push_back(8'h09);
        default: byte_q.push_back(8'h0D);
      endcase
    end else byte_q.push_back(8'($urandom_range(1, 255)));
  endtask

  initial begin
    int target;
    lexer_clear();
    for (int i = 0; i < 9; i++) kw_buf[i] = 8'd0;

    // directed: operators, high bytes, end inside literals and comments
    add_text("a<<=b"); byte_q.push_back(8'hFF); byte_q.push_back(8'h80);
    add_text("'\\"); end_source();
    add_text("\"ab\\"); end_source();
    add_text("/*x"); end_source();
    add_text("'"); end_source();
    end_source();
    add_text("x//c"); end_source();

    // random sources of token-like pieces with noise mixed in
    target = byte_q.size() + 140;
    while (byte_q.size() < target) begin
      repeat ($urandom_range(1, 12)) add_piece();
      if ($urandom_range(0, 4) != 0) end_source();
    end
    end_source();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (byte_q.size() == 0 && !source_valid && tokens_due.size() == 0);
    repeat (30) @(posedge clk);

    $display("Ran %0d source bytes in %0d sources; %0d tokens checked, %0d errors.",
             n_bytes, n_sources, n_tokens, n_errors);
    if (n_errors == 0 && tokens_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
src/cst_pkg.sv
src/c_source_tokenizer.sv
tb/testbench.sv
